[sv/bsv_pkg.sv]
`timescale 1ns / 1ps

package bsv_pkg;

    localparam int STACK_DEPTH  = 4096;
    localparam int STACK_AW     = $clog2(STACK_DEPTH);
    localparam int CNT_W        = $clog2(STACK_DEPTH + 1);
    localparam int LENGTH_LIMIT = 8192;
    localparam int LEN_W        = 14;
    localparam int SUM_W        = 17;

    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    // stack entry: bit 0 dictionary, bit 1 odd count of contained objects
    typedef logic [1:0] t_entry;

    localparam t_entry ENTRY_LIST     = 2'b00;
    localparam t_entry ENTRY_DICT     = 2'b01;
    localparam t_entry ENTRY_PARITY   = 2'b10;
    localparam t_entry ENTRY_DICT_ODD = 2'b11;

    typedef struct packed {
        logic   clear;
        logic   push;
        logic   pop;
        logic   load;
        t_entry value;
    } t_stack_cmd;

endpackage

[sv/bsv_byte_if.sv]
`timescale 1ns / 1ps

interface bsv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last;

    modport source (output valid, output byte_value, output last, input ready);
    modport sink   (input valid, input byte_value, input last, output ready);
endinterface

[sv/bsv_result_if.sv]
`timescale 1ns / 1ps

interface bsv_result_if;
    logic                     valid;
    logic                     ready;
    logic                     verdict;
    logic [bsv_pkg::LEN_W-1:0] error_pos;

    modport source (output valid, output verdict, output error_pos, input ready);
    modport sink   (input valid, input verdict, input error_pos, output ready);
endinterface

[sv/bsv_cfg_if.sv]
`timescale 1ns / 1ps

interface bsv_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [bsv_pkg::LEN_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/bsv_stack.sv]
`timescale 1ns / 1ps

// Nesting stack. The top entry lives in a register, the rest in memory.
// The entry just below the top is prefetched every cycle so a pop can
// use it at once.
module bsv_stack (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bsv_pkg::t_stack_cmd       i_cmd,
    output bsv_pkg::t_entry           o_top,
    output bsv_pkg::t_entry           o_below,
    output logic [bsv_pkg::CNT_W-1:0] o_count
);

    logic [bsv_pkg::CNT_W-1:0]    r_count;
    logic [bsv_pkg::CNT_W-1:0]    n_count;
    bsv_pkg::t_entry              r_top;
    bsv_pkg::t_entry              r_below;
    bsv_pkg::t_entry              r_mem [bsv_pkg::STACK_DEPTH];
    logic [bsv_pkg::CNT_W-1:0]    w_waddr_full;
    logic [bsv_pkg::CNT_W-1:0]    w_raddr_full;
    logic [bsv_pkg::STACK_AW-1:0] w_waddr;
    logic [bsv_pkg::STACK_AW-1:0] w_raddr;

    always_comb begin
        n_count = r_count;
        if (i_cmd.clear) begin
            n_count = '0;
        end else if (i_cmd.push) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.pop) begin
            n_count = r_count - 1'b1;
        end
    end

    assign w_waddr_full = r_count - 1'b1;
    assign w_raddr_full = n_count - bsv_pkg::CNT_W'(2);
    assign w_waddr      = w_waddr_full[bsv_pkg::STACK_AW-1:0];
    assign w_raddr      = w_raddr_full[bsv_pkg::STACK_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push || i_cmd.load) begin
            r_top <= i_cmd.value;
        end
    end

    // old top goes to memory on a push; it is also the new "below" entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && (r_count != '0)) begin
            r_mem[w_waddr] <= r_top;
        end
        if (i_cmd.push) begin
            r_below <= r_top;
        end else begin
            r_below <= r_mem[w_raddr];
        end
    end

    assign o_top   = r_top;
    assign o_below = r_below;
    assign o_count = r_count;

endmodule

[sv/bencode_stream_validator.sv]
`timescale 1ns / 1ps

// The last byte of a message passes the input register, then the result register.
// Throughput: one byte per cycle, sustained, as long as results are taken.
// Every byte is checked combinationally between the input register and the parser
// state and result registers, using the top two stack entries held in registers.
// Reset (synchronous, active low) clears parser state and sets max_len to 8192;
// the nesting stack memory is not cleared, an entry is always written before read.
module bencode_stream_validator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    bsv_byte_if.sink            i_byte,
    bsv_cfg_if.sink             i_cfg,
    bsv_result_if.source        o_result
);

    localparam logic [2:0] MODE_START       = 3'd0;
    localparam logic [2:0] MODE_STR_LEN     = 3'd1;
    localparam logic [2:0] MODE_STR_CONTENT = 3'd2;
    localparam logic [2:0] MODE_INT_START   = 3'd3;
    localparam logic [2:0] MODE_INT_DIGITS  = 3'd4;

    localparam int LW = bsv_pkg::LEN_W;
    localparam int SW = bsv_pkg::SUM_W;
    localparam logic [LW-1:0] LIMIT = LW'(bsv_pkg::LENGTH_LIMIT);

    // configuration
    logic [LW-1:0] r_max_len;

    // input register
    logic          r_in_vld;
    logic [7:0]    r_byte;
    logic          r_last;

    // parser state
    logic [2:0]    r_mode,     n_mode;
    logic [LW-1:0] r_pos,      n_pos;
    logic [LW-1:0] r_decl,     n_decl;
    logic [LW-1:0] r_rem,      n_rem;
    logic          r_szl,      n_szl;
    logic          r_izl,      n_izl;
    logic          r_done,     n_done;
    logic          r_err_seen;
    logic [LW-1:0] r_err_pos;

    // result register
    logic          r_out_vld;
    logic          r_verdict;
    logic [LW-1:0] r_out_pos;

    logic                      w_fire;
    logic                      w_err;
    logic                      w_push;
    logic                      w_pop;
    logic                      w_finish;
    logic                      w_upd;
    logic [LW-1:0]             w_lim;
    logic [SW-1:0]             w_lim_x;
    logic [SW-1:0]             w_base;
    logic [3:0]                w_digit;
    logic                      w_is_digit;
    logic [SW-1:0]             w_decl_mul;
    logic [LW-1:0]             w_decl_sat;
    logic                      w_fin_empty;
    bsv_pkg::t_entry           w_fin_entry;
    bsv_pkg::t_entry           w_fin_value;
    logic                      w_err_final;
    logic                      w_done_final;
    logic [LW-1:0]             w_epos_final;
    bsv_pkg::t_stack_cmd       w_cmd;
    bsv_pkg::t_entry           w_top;
    bsv_pkg::t_entry           w_below;
    logic [bsv_pkg::CNT_W-1:0] w_count;

    bsv_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_top   (w_top),
        .o_below (w_below),
        .o_count (w_count)
    );

    // handshakes
    assign w_fire       = r_in_vld && (!r_out_vld || o_result.ready);
    assign i_byte.ready = !r_in_vld || w_fire;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= LIMIT;
        end else if (i_cfg.valid) begin
            r_max_len <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_vld <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_byte <= i_byte.byte_value;
            r_last <= i_byte.last;
        end
    end

    // byte check
    assign w_lim      = (r_max_len > LIMIT) ? LIMIT : r_max_len;
    assign w_lim_x    = SW'(w_lim);
    assign w_base     = SW'(r_pos) + SW'(w_count);
    assign w_digit    = 4'(r_byte - bsv_pkg::CH_0);
    assign w_is_digit = r_byte inside {[bsv_pkg::CH_0:bsv_pkg::CH_9]};
    assign w_decl_mul = (SW'(r_decl) << 3) + (SW'(r_decl) << 1) + SW'(w_digit);

    // declared string length saturates at limit + 1
    always_comb begin
        if ((r_decl > w_lim) || (w_decl_mul > w_lim_x)) begin
            w_decl_sat = w_lim + 1'b1;
        end else begin
            w_decl_sat = w_decl_mul[LW-1:0];
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_decl   = r_decl;
        n_rem    = r_rem;
        n_szl    = r_szl;
        n_izl    = r_izl;
        w_err    = 1'b0;
        w_push   = 1'b0;
        w_pop    = 1'b0;
        w_finish = 1'b0;
        if (r_done || (r_pos >= w_lim)) begin
            w_err = 1'b1;
        end else begin
            case (r_mode)
                MODE_START: begin
                    if ((r_byte == bsv_pkg::CH_L) || (r_byte == bsv_pkg::CH_D)) begin
                        if (w_count >= bsv_pkg::CNT_W'(bsv_pkg::STACK_DEPTH)) begin
                            w_err = 1'b1;
                        end else if (w_base + SW'(2) > w_lim_x) begin
                            w_err = 1'b1;
                        end else begin
                            w_push = 1'b1;
                        end
                    end else if (r_byte == bsv_pkg::CH_E) begin
                        if (w_count == '0) begin
                            w_err = 1'b1;
                        end else if (w_top == bsv_pkg::ENTRY_DICT_ODD) begin
                            w_err = 1'b1;
                        end else begin
                            w_pop    = 1'b1;
                            w_finish = 1'b1;
                        end
                    end else if (r_byte == bsv_pkg::CH_I) begin
                        if (w_base + SW'(3) > w_lim_x) begin
                            w_err = 1'b1;
                        end else begin
                            n_mode = MODE_INT_START;
                        end
                    end else if (w_is_digit) begin
                        n_decl = LW'(w_digit);
                        n_szl  = (w_digit == 4'd0);
                        if (w_base + SW'(2) + SW'(w_digit) > w_lim_x) begin
                            w_err = 1'b1;
                        end else begin
                            n_mode = MODE_STR_LEN;
                        end
                    end else begin
                        w_err = 1'b1;
                    end
                end
                MODE_STR_LEN: begin
                    if (w_is_digit) begin
                        n_decl = w_decl_sat;
                        if (r_szl) begin
                            w_err = 1'b1;
                        end else if (w_base + SW'(2) + SW'(w_decl_sat) > w_lim_x) begin
                            w_err = 1'b1;
                        end
                    end else if (r_byte == bsv_pkg::CH_COLON) begin
                        if (w_base + SW'(1) + SW'(r_decl) > w_lim_x) begin
                            w_err = 1'b1;
                        end else begin
                            n_rem = r_decl;
                            if (r_decl == '0) begin
                                n_mode   = MODE_START;
                                w_finish = 1'b1;
                            end else begin
                                n_mode = MODE_STR_CONTENT;
                            end
                        end
                    end else begin
                        w_err = 1'b1;
                    end
                end
                MODE_STR_CONTENT: begin
                    n_rem = r_rem - 1'b1;
                    if (r_rem == LW'(1)) begin
                        n_mode   = MODE_START;
                        w_finish = 1'b1;
                    end
                end
                MODE_INT_START: begin
                    if (!w_is_digit) begin
                        w_err = 1'b1;
                    end else begin
                        n_izl = (w_digit == 4'd0);
                        if (w_base + SW'(2) > w_lim_x) begin
                            w_err = 1'b1;
                        end else begin
                            n_mode = MODE_INT_DIGITS;
                        end
                    end
                end
                MODE_INT_DIGITS: begin
                    if (r_izl && (r_byte != bsv_pkg::CH_E)) begin
                        w_err = 1'b1;
                    end else if (w_is_digit) begin
                        if (w_base + SW'(2) > w_lim_x) begin
                            w_err = 1'b1;
                        end
                    end else if (r_byte == bsv_pkg::CH_E) begin
                        n_mode   = MODE_START;
                        w_finish = 1'b1;
                    end else begin
                        w_err = 1'b1;
                    end
                end
                default: begin
                    w_err = 1'b1;
                end
            endcase
        end
    end

    // completing an object: flags the top level as done, or flips the
    // enclosing dictionary's parity (after a pop the enclosing one is below)
    assign w_fin_empty = w_pop ? (w_count == bsv_pkg::CNT_W'(1)) : (w_count == '0);
    assign w_fin_entry = w_pop ? w_below : w_top;
    assign w_fin_value = w_fin_entry[0] ? (w_fin_entry ^ bsv_pkg::ENTRY_PARITY) : w_fin_entry;

    always_comb begin
        n_done = r_done;
        if (w_finish && w_fin_empty) begin
            n_done = 1'b1;
        end
    end

    assign w_upd = w_fire && !r_err_seen && !w_err;

    always_comb begin
        w_cmd.clear = w_fire && r_last;
        w_cmd.push  = w_upd && w_push;
        w_cmd.pop   = w_upd && w_pop;
        w_cmd.load  = w_upd && (w_pop || (w_finish && !w_fin_empty));
        w_cmd.value = w_push ? ((r_byte == bsv_pkg::CH_D) ? bsv_pkg::ENTRY_DICT
                                                          : bsv_pkg::ENTRY_LIST)
                             : w_fin_value;
    end

    assign n_pos        = (r_pos == LIMIT) ? r_pos : r_pos + 1'b1;
    assign w_err_final  = r_err_seen || w_err;
    assign w_epos_final = r_err_seen ? r_err_pos : r_pos;
    assign w_done_final = !w_err_final && n_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_START;
            r_pos      <= '0;
            r_decl     <= '0;
            r_rem      <= '0;
            r_szl      <= 1'b0;
            r_izl      <= 1'b0;
            r_done     <= 1'b0;
            r_err_seen <= 1'b0;
            r_err_pos  <= '0;
        end else if (w_fire) begin
            if (r_last) begin
                r_mode     <= MODE_START;
                r_pos      <= '0;
                r_decl     <= '0;
                r_rem      <= '0;
                r_szl      <= 1'b0;
                r_izl      <= 1'b0;
                r_done     <= 1'b0;
                r_err_seen <= 1'b0;
                r_err_pos  <= '0;
            end else begin
                r_pos <= n_pos;
                if (!r_err_seen && w_err) begin
                    r_err_seen <= 1'b1;
                    r_err_pos  <= r_pos;
                end else if (w_upd) begin
                    r_mode <= n_mode;
                    r_decl <= n_decl;
                    r_rem  <= n_rem;
                    r_szl  <= n_szl;
                    r_izl  <= n_izl;
                    r_done <= n_done;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire && r_last) begin
            r_out_vld <= 1'b1;
        end else if (o_result.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_last) begin
            r_verdict <= !w_done_final;
            if (w_err_final) begin
                r_out_pos <= w_epos_final;
            end else if (w_done_final) begin
                r_out_pos <= '0;
            end else begin
                r_out_pos <= n_pos;
            end
        end
    end

    assign o_result.valid     = r_out_vld;
    assign o_result.verdict   = r_verdict;
    assign o_result.error_pos = r_out_pos;

    ap_ok_has_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_verdict) |-> (r_out_pos == '0))
        else $error("ok result with nonzero error position");

    ap_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_last) |=> ((r_pos == '0) && (w_count == '0) && !r_err_seen))
        else $error("message state not cleared after last word");

    ap_err_before_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err_seen |-> (r_err_pos <= r_pos))
        else $error("first error position beyond current position");

    ap_content_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_STR_CONTENT) |-> (r_rem != '0))
        else $error("string content mode with nothing remaining");

    ap_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= bsv_pkg::CNT_W'(bsv_pkg::STACK_DEPTH))
        else $error("nesting stack overflow");

endmodule
